// ----- rtl/fstp_pkg.sv -----
package fstp_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;
   localparam int DIV_NUM_W   = 64;
   localparam int DIV_DEN_W   = 32;
   localparam int MUL_W       = 34;
   localparam int CSR_ADDR_W  = 5;

   localparam logic [2:0] REG_SETPOINT = 3'd0;
   localparam logic [2:0] REG_ERR_SPAN = 3'd1;
   localparam logic [2:0] REG_CHG_SPAN = 3'd2;
   localparam logic [2:0] REG_KP_LIM   = 3'd3;
   localparam logic [2:0] REG_KI_LIM   = 3'd4;
   localparam logic [2:0] REG_KD_LIM   = 3'd5;

   localparam logic [15:0] SETPOINT_RST = 16'd3000;
   localparam logic [15:0] ERR_SPAN_RST = 16'd2000;
   localparam logic [15:0] CHG_SPAN_RST = 16'd500;
   localparam logic [23:0] KP_LIM_RST   = 24'd3276800;
   localparam logic [23:0] KI_LIM_RST   = 24'd6554;
   localparam logic [23:0] KD_LIM_RST   = 24'd655;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LVL_E,
      ST_LVL_C,
      ST_WGT,
      ST_GMUL,
      ST_GDIV,
      ST_CMUL,
      ST_DONE
   } state_type;

   typedef logic signed [2:0] rule_type;

   localparam rule_type KP_RULES [0:6][0:6] = '{
      '{3, 3, 2, 2, 1, 0, 0},     '{3, 3, 2, 1, 1, 0, -1},
      '{2, 2, 2, 1, 0, -1, -1},   '{2, 2, 1, 0, -1, -2, -2},
      '{1, 1, 0, -1, -1, -2, -2}, '{1, 0, -1, -2, -2, -2, -3},
      '{0, 0, -2, -2, -2, -3, -3}};
   localparam rule_type KI_RULES [0:6][0:6] = '{
      '{-3, -3, -2, -2, -1, 0, 0}, '{-3, -3, -2, -1, -1, 0, 0},
      '{-3, -2, -1, -1, 0, 1, 1},  '{-2, -2, -1, 0, 1, 2, 2},
      '{-2, -1, 0, 1, 1, 2, 3},    '{0, 0, 1, 1, 2, 3, 3},
      '{0, 0, 1, 2, 2, 3, 3}};
   localparam rule_type KD_RULES [0:6][0:6] = '{
      '{1, -1, -3, -3, -3, -2, 1}, '{1, -1, -3, -2, -2, -1, 0},
      '{0, -1, -2, -2, -1, -1, 0}, '{0, -1, -1, -1, -1, -1, 0},
      '{0, 0, 0, 0, 0, 0, 0},      '{3, -1, 1, 1, 1, 1, 3},
      '{3, 2, 2, 2, 1, 1, 3}};

endpackage

// ----- rtl/fstp_div.sv -----
module fstp_div #(
   parameter int NUM_W = fstp_pkg::DIV_NUM_W,
   parameter int DEN_W = fstp_pkg::DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   // restoring division, one quotient bit a cycle
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- rtl/fuzzy_self_tuning_pid_unit.sv -----
// Fuzzy self-tuning incremental PID. Each measurement beat forms the error against the
// setpoint and its change, maps both onto fuzzy levels -3..3, weights the kp/ki/kd rule
// tables, steps and saturates the three gains and returns one result beat with the 16 bit
// correction and the updated gains. One shared multiplier and one shared bit-serial divider
// do all the work. The divider runs twice per sample, once for each fuzzy level; then come
// the rule weighting, the three gain steps (the divide by three is a reciprocal multiply)
// and the correction sum. req_tready is low while a sample is being worked on and while
// the result beat waits to be taken, so no new measurement beat is accepted before the
// last result has gone out.
module fuzzy_self_tuning_pid_unit #(
   parameter int SAMPLE_BITS = fstp_pkg::SAMPLE_BITS,
   parameter int FRAC_BITS   = fstp_pkg::FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,  // measurement
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // correction, prop_gain, integ_gain, deriv_gain
   output logic [111:0]                          rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [fstp_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   localparam int EW  = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
   localparam int CW  = EW + 1;
   localparam int D2W = EW + 2;
   localparam int LW  = FRAC_BITS + 3;
   localparam int MUW = FRAC_BITS + 1;
   localparam int SW  = 2 * FRAC_BITS + 4;
   localparam int MW  = fstp_pkg::MUL_W;
   localparam int PW  = 2 * MW;
   localparam int NW  = fstp_pkg::DIV_NUM_W;
   localparam int DW  = fstp_pkg::DIV_DEN_W;
   localparam logic [LW-1:0]  THREE_ONE = LW'(3) << FRAC_BITS;
   localparam logic [MUW-1:0] ONE_MU    = MUW'(1) << FRAC_BITS;
   // floor(y / 3) = (y * RECIP3) >> R3_SHIFT for any 32 bit y
   localparam logic [MW-1:0]  RECIP3    = MW'(32'hAAAA_AAAB);
   localparam int             R3_SHIFT  = 33;

   fstp_pkg::state_type state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       phase_ff, phase_in;

   logic [15:0] setpoint_ff, err_span_ff, chg_span_ff;
   logic [23:0] kp_lim_ff, ki_lim_ff, kd_lim_ff;

   logic signed [EW-1:0] e_ff, e_in, last_ff, last_in, prior_ff, prior_in;
   logic signed [CW-1:0] ec_ff, ec_in;
   logic [LW-1:0]        ue_ff, ue_in, uc_ff, uc_in;
   logic signed [SW-1:0] sp_ff, sp_in, si_ff, si_in, sd_ff, sd_in;
   logic [31:0]          kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [63:0]   corr_ff, corr_in;

   logic signed [MW-1:0] mul_a, mul_b;
   logic                 div_start, div_done, div_neg;
   logic [NW-1:0]        div_num, div_quo;
   logic [DW-1:0]        div_den;

   // fuzzy split of both levels
   logic [2:0]     ei0, ei1, ci0, ci1;
   logic [MUW-1:0] em0, em1, cm0, cm1;

   always_comb begin
      if (ue_ff[LW-1:FRAC_BITS] >= 3'd6) begin
         ei0 = 3'd6;
         ei1 = 3'd6;
         em0 = ONE_MU;
         em1 = '0;
      end else begin
         ei0 = ue_ff[LW-1:FRAC_BITS];
         ei1 = ue_ff[LW-1:FRAC_BITS] + 3'd1;
         em1 = MUW'(ue_ff[FRAC_BITS-1:0]);
         em0 = ONE_MU - em1;
      end
      if (uc_ff[LW-1:FRAC_BITS] >= 3'd6) begin
         ci0 = 3'd6;
         ci1 = 3'd6;
         cm0 = ONE_MU;
         cm1 = '0;
      end else begin
         ci0 = uc_ff[LW-1:FRAC_BITS];
         ci1 = uc_ff[LW-1:FRAC_BITS] + 3'd1;
         cm1 = MUW'(uc_ff[FRAC_BITS-1:0]);
         cm0 = ONE_MU - cm1;
      end
   end

   function automatic logic signed [SW-1:0] scale_rule(logic signed [SW-1:0] w,
                                                       fstp_pkg::rule_type r);
      logic signed [SW-1:0] w2;
      begin
         w2 = w <<< 1;
         case (r)
            3'sd1:   scale_rule = w;
            3'sd2:   scale_rule = w2;
            3'sd3:   scale_rule = w2 + w;
            -3'sd1:  scale_rule = -w;
            -3'sd2:  scale_rule = -w2;
            -3'sd3:  scale_rule = -(w2 + w);
            default: scale_rule = '0;
         endcase
      end
   endfunction

   // selected operands
   logic [2:0]           row, col;
   logic signed [SW-1:0] wgt, sum_sel, sum_mag;
   logic [SW-1:0]        cf_mag;
   logic signed [LW-1:0] cf;
   logic [23:0]          lim_sel;
   logic [31:0]          gain_sel;
   logic signed [D2W-1:0] diff_sel;
   logic [PW-1:0]        prod_mag;
   logic [LW-1:0]        lvl_mag, lvl_u;
   logic signed [39:0]   gain_sum, step;
   logic [31:0]          gain_new, step_mag;
   logic                 step_neg;

   assign row     = cnt_ff[1] ? ei1 : ei0;
   assign col     = cnt_ff[0] ? ci1 : ci0;
   assign wgt     = SW'(prod_ff);
   assign sum_sel = (cnt_ff == 2'd0) ? sp_ff : ((cnt_ff == 2'd1) ? si_ff : sd_ff);
   assign sum_mag = sum_sel[SW-1] ? -sum_sel : sum_sel;
   assign cf_mag  = SW'(sum_mag) >> FRAC_BITS;
   assign cf      = sum_sel[SW-1] ? -$signed(cf_mag[LW-1:0]) : $signed(cf_mag[LW-1:0]);
   assign lim_sel = (cnt_ff == 2'd0) ? kp_lim_ff : ((cnt_ff == 2'd1) ? ki_lim_ff : kd_lim_ff);
   assign gain_sel = (cnt_ff == 2'd0) ? kp_ff : ((cnt_ff == 2'd1) ? ki_ff : kd_ff);
   assign prod_mag = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);

   always_comb begin
      case (cnt_ff)
         2'd0:    diff_sel = D2W'(ec_ff);
         2'd1:    diff_sel = D2W'(e_ff);
         default: diff_sel = D2W'(e_ff) - (D2W'(last_ff) <<< 1) + D2W'(prior_ff);
      endcase
   end

   // shared multiplier, registered
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         fstp_pkg::ST_WGT: begin
            mul_a = MW'(cnt_ff[1] ? em1 : em0);
            mul_b = MW'(cnt_ff[0] ? cm1 : cm0);
         end
         fstp_pkg::ST_GMUL: begin
            mul_a = MW'(lim_sel);
            mul_b = MW'(cf);
         end
         fstp_pkg::ST_GDIV: begin
            // |limit * centroid| / 2^F, then divided by three
            mul_a = MW'(prod_mag >> FRAC_BITS);
            mul_b = RECIP3;
         end
         fstp_pkg::ST_CMUL: begin
            mul_a = MW'(gain_sel);
            mul_b = MW'(diff_sel);
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // shared divider operands
   always_comb begin
      div_num = '0;
      div_den = DW'(1);
      div_neg = 1'b0;
      case (state_ff)
         fstp_pkg::ST_LVL_E: begin
            div_neg = e_ff[EW-1];
            div_num = (NW'(e_ff[EW-1] ? -e_ff : e_ff) * NW'(3)) << FRAC_BITS;
            div_den = (err_span_ff == '0) ? DW'(1) : DW'(err_span_ff);
         end
         fstp_pkg::ST_LVL_C: begin
            div_neg = ec_ff[CW-1];
            div_num = (NW'(ec_ff[CW-1] ? -ec_ff : ec_ff) * NW'(3)) << FRAC_BITS;
            div_den = (chg_span_ff == '0) ? DW'(1) : DW'(chg_span_ff);
         end
         default: ;
      endcase
   end

   assign div_start = !phase_ff && (state_ff == fstp_pkg::ST_LVL_E ||
                      state_ff == fstp_pkg::ST_LVL_C);

   fstp_div #(
      .NUM_W (NW),
      .DEN_W (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // level clamp and offset to 0..6
   assign lvl_mag = (div_quo > NW'(THREE_ONE)) ? THREE_ONE : div_quo[LW-1:0];
   assign lvl_u   = div_neg ? THREE_ONE - lvl_mag : THREE_ONE + lvl_mag;

   // the step takes the sign of the centroid, the limit being unsigned
   assign step_neg = sum_sel[SW-1];
   assign step_mag = prod_ff[R3_SHIFT+31:R3_SHIFT];
   assign step     = step_neg ? -$signed(40'(step_mag)) : $signed(40'(step_mag));
   assign gain_sum = $signed({8'd0, gain_sel}) + step;
   assign gain_new = gain_sum[39] ? 32'd0 :
                     ((gain_sum[39:32] != 8'd0) ? 32'hFFFF_FFFF : gain_sum[31:0]);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      e_in     = e_ff;
      ec_in    = ec_ff;
      last_in  = last_ff;
      prior_in = prior_ff;
      ue_in    = ue_ff;
      uc_in    = uc_ff;
      sp_in    = sp_ff;
      si_in    = si_ff;
      sd_in    = sd_ff;
      kp_in    = kp_ff;
      ki_in    = ki_ff;
      kd_in    = kd_ff;
      corr_in  = corr_ff;
      case (state_ff)
         fstp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               e_in     = $signed(EW'(setpoint_ff)) - $signed(EW'(req_tdata[SAMPLE_BITS-1:0]));
               ec_in    = CW'(e_in) - CW'(last_ff);
               sp_in    = '0;
               si_in    = '0;
               sd_in    = '0;
               corr_in  = '0;
               phase_in = 1'b0;
               cnt_in   = 2'd0;
               state_in = fstp_pkg::ST_LVL_E;
            end
         end
         fstp_pkg::ST_LVL_E: begin
            phase_in = 1'b1;
            if (phase_ff && div_done) begin
               ue_in    = lvl_u;
               phase_in = 1'b0;
               state_in = fstp_pkg::ST_LVL_C;
            end
         end
         fstp_pkg::ST_LVL_C: begin
            phase_in = 1'b1;
            if (phase_ff && div_done) begin
               uc_in    = lvl_u;
               phase_in = 1'b0;
               state_in = fstp_pkg::ST_WGT;
            end
         end
         fstp_pkg::ST_WGT: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               sp_in  = sp_ff + scale_rule(wgt, fstp_pkg::KP_RULES[row][col]);
               si_in  = si_ff + scale_rule(wgt, fstp_pkg::KI_RULES[row][col]);
               sd_in  = sd_ff + scale_rule(wgt, fstp_pkg::KD_RULES[row][col]);
               cnt_in = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_in = fstp_pkg::ST_GMUL;
               end
            end
         end
         fstp_pkg::ST_GMUL: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               state_in = fstp_pkg::ST_GDIV;
            end
         end
         fstp_pkg::ST_GDIV: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               case (cnt_ff)
                  2'd0:    kp_in = gain_new;
                  2'd1:    ki_in = gain_new;
                  default: kd_in = gain_new;
               endcase
               if (cnt_ff == 2'd2) begin
                  cnt_in   = 2'd0;
                  state_in = fstp_pkg::ST_CMUL;
               end else begin
                  cnt_in   = cnt_ff + 2'd1;
                  state_in = fstp_pkg::ST_GMUL;
               end
            end
         end
         fstp_pkg::ST_CMUL: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               corr_in = corr_ff + 64'(prod_ff);
               cnt_in  = cnt_ff + 2'd1;
               if (cnt_ff == 2'd2) begin
                  prior_in = last_ff;
                  last_in  = e_ff;
                  state_in = fstp_pkg::ST_DONE;
               end
            end
         end
         fstp_pkg::ST_DONE: begin
            if (rsp_tready) begin
               state_in = fstp_pkg::ST_IDLE;
            end
         end
         default: state_in = fstp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fstp_pkg::ST_IDLE;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
         last_ff  <= '0;
         prior_ff <= '0;
         kp_ff    <= '0;
         ki_ff    <= '0;
         kd_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         last_ff  <= last_in;
         prior_ff <= prior_in;
         kp_ff    <= kp_in;
         ki_ff    <= ki_in;
         kd_ff    <= kd_in;
      end
      e_ff    <= e_in;
      ec_ff   <= ec_in;
      ue_ff   <= ue_in;
      uc_ff   <= uc_in;
      sp_ff   <= sp_in;
      si_ff   <= si_in;
      sd_ff   <= sd_in;
      prod_ff <= prod_in;
      corr_ff <= corr_in;
   end

   // configuration registers
   logic       csr_wr;
   logic [2:0] csr_idx;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= fstp_pkg::SETPOINT_RST;
         err_span_ff <= fstp_pkg::ERR_SPAN_RST;
         chg_span_ff <= fstp_pkg::CHG_SPAN_RST;
         kp_lim_ff   <= fstp_pkg::KP_LIM_RST;
         ki_lim_ff   <= fstp_pkg::KI_LIM_RST;
         kd_lim_ff   <= fstp_pkg::KD_LIM_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            fstp_pkg::REG_SETPOINT: setpoint_ff <= csr_pwdata[15:0];
            fstp_pkg::REG_ERR_SPAN: err_span_ff <= csr_pwdata[15:0];
            fstp_pkg::REG_CHG_SPAN: chg_span_ff <= csr_pwdata[15:0];
            fstp_pkg::REG_KP_LIM:   kp_lim_ff   <= csr_pwdata[23:0];
            fstp_pkg::REG_KI_LIM:   ki_lim_ff   <= csr_pwdata[23:0];
            fstp_pkg::REG_KD_LIM:   kd_lim_ff   <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         fstp_pkg::REG_SETPOINT: csr_prdata = 32'(setpoint_ff);
         fstp_pkg::REG_ERR_SPAN: csr_prdata = 32'(err_span_ff);
         fstp_pkg::REG_CHG_SPAN: csr_prdata = 32'(chg_span_ff);
         fstp_pkg::REG_KP_LIM:   csr_prdata = 32'(kp_lim_ff);
         fstp_pkg::REG_KI_LIM:   csr_prdata = 32'(ki_lim_ff);
         fstp_pkg::REG_KD_LIM:   csr_prdata = 32'(kd_lim_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // correction: truncate toward zero, saturate to 16 bits
   logic [63:0] corr_mag, corr_int;
   logic [15:0] corr_out;

   assign corr_mag = corr_ff[63] ? 64'(-corr_ff) : 64'(corr_ff);
   assign corr_int = corr_mag >> FRAC_BITS;

   always_comb begin
      if (corr_ff[63]) begin
         corr_out = (corr_int > 64'd32768) ? 16'h8000 : 16'(-corr_int);
      end else begin
         corr_out = (corr_int > 64'd32767) ? 16'h7FFF : corr_int[15:0];
      end
   end

   assign req_tready = (state_ff == fstp_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == fstp_pkg::ST_DONE);
   assign rsp_tdata  = {kd_ff, ki_ff, kp_ff, corr_out};

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while result pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready right after accepting a beat");

   a_gains_hold_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fstp_pkg::ST_IDLE) |=> ($stable(kp_ff) && $stable(ki_ff) && $stable(kd_ff)))
      else $error("gain changed without a sample");

   a_history_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (last_ff == e_ff))
      else $error("error history not updated with result");
`endif

endmodule

// ----- tb/sv/fstp_checker.sv -----
module fstp_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [15:0]                     req_tdata,   // measurement
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // correction, prop_gain, integ_gain, deriv_gain
   input  logic [111:0]                    rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fstp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   input  logic                            csr_pready,
   output int                              errors,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint UNIT = longint'(1) << fstp_pkg::FRAC_BITS;

   typedef struct {
      logic signed [15:0] correction;
      logic [31:0]        prop_gain;
      logic [31:0]        integ_gain;
      logic [31:0]        deriv_gain;
   } pid_result_type;

   localparam int P_TAB [7][7] = '{
      '{3, 3, 2, 2, 1, 0, 0},     '{3, 3, 2, 1, 1, 0, -1},
      '{2, 2, 2, 1, 0, -1, -1},   '{2, 2, 1, 0, -1, -2, -2},
      '{1, 1, 0, -1, -1, -2, -2}, '{1, 0, -1, -2, -2, -2, -3},
      '{0, 0, -2, -2, -2, -3, -3}};
   localparam int I_TAB [7][7] = '{
      '{-3, -3, -2, -2, -1, 0, 0}, '{-3, -3, -2, -1, -1, 0, 0},
      '{-3, -2, -1, -1, 0, 1, 1},  '{-2, -2, -1, 0, 1, 2, 2},
      '{-2, -1, 0, 1, 1, 2, 3},    '{0, 0, 1, 1, 2, 3, 3},
      '{0, 0, 1, 2, 2, 3, 3}};
   localparam int D_TAB [7][7] = '{
      '{1, -1, -3, -3, -3, -2, 1}, '{1, -1, -3, -2, -2, -1, 0},
      '{0, -1, -2, -2, -1, -1, 0}, '{0, -1, -1, -1, -1, -1, 0},
      '{0, 0, 0, 0, 0, 0, 0},      '{3, -1, 1, 1, 1, 1, 3},
      '{3, 2, 2, 2, 1, 1, 3}};

   logic [15:0] setpoint, err_span, chg_span;
   logic [23:0] kp_lim, ki_lim, kd_lim;
   longint      err_1, err_2;
   logic [31:0] kp_gain, ki_gain, kd_gain;
   pid_result_type results_due [$];

   // fuzzy level in Q.F clamped to +-3, then split into index and two memberships
   function automatic void fuzzify(input longint x, input logic [15:0] span,
                                   output int idx [2], output longint mu [2]);
      longint d, q, u;
      d = (span == 0) ? 1 : longint'(span);
      q = (3 * x * UNIT) / d;
      if (q > 3 * UNIT) q = 3 * UNIT;
      if (q < -3 * UNIT) q = -3 * UNIT;
      u = q + 3 * UNIT;
      if (u / UNIT >= 6) begin
         idx[0] = 6; idx[1] = 6; mu[0] = UNIT; mu[1] = 0;
      end else begin
         idx[0] = int'(u / UNIT); idx[1] = idx[0] + 1;
         mu[1] = u % UNIT; mu[0] = UNIT - mu[1];
      end
   endfunction

   function automatic logic [31:0] step_gain(input logic [31:0] gain, input logic [23:0] lim,
                                             input longint cent);
      longint g;
      g = longint'(gain) + (longint'(lim) * (cent / UNIT)) / (3 * UNIT);
      if (g < 0) g = 0;
      if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
      return g[31:0];
   endfunction

   function automatic pid_result_type next_correction(input logic [15:0] meas);
      pid_result_type res;
      longint e, ec, sp, si, sd, w, acc, mag;
      int ei [2], ci [2];
      longint em [2], cm [2];
      e = longint'(setpoint) - longint'(meas);
      ec = e - err_1;
      fuzzify(e, err_span, ei, em);
      fuzzify(ec, chg_span, ci, cm);
      sp = 0; si = 0; sd = 0;
      for (int a = 0; a < 2; a++)
         for (int b = 0; b < 2; b++) begin
            w = em[a] * cm[b];
            sp += w * P_TAB[ei[a]][ci[b]];
            si += w * I_TAB[ei[a]][ci[b]];
            sd += w * D_TAB[ei[a]][ci[b]];
         end
      kp_gain = step_gain(kp_gain, kp_lim, sp);
      ki_gain = step_gain(ki_gain, ki_lim, si);
      kd_gain = step_gain(kd_gain, kd_lim, sd);
      acc = longint'(kp_gain) * ec + longint'(ki_gain) * e
          + longint'(kd_gain) * (e - 2 * err_1 + err_2);
      mag = ((acc < 0) ? -acc : acc) / UNIT;
      if (acc < 0) mag = -mag;
      if (mag > 32767) mag = 32767;
      if (mag < -32768) mag = -32768;
      err_2 = err_1;
      err_1 = e;
      res.correction = mag[15:0];
      res.prop_gain = kp_gain;
      res.integ_gain = ki_gain;
      res.deriv_gain = kd_gain;
      return res;
   endfunction

   function automatic int field_mismatch(input string name, input longint exp_v,
                                         input longint got_v);
      if (exp_v == got_v) return 0;
      $display("%0t %s expected %0d actual %0d", $time, name, exp_v, got_v);
      return 1;
   endfunction

   always @(posedge clock) begin
      pid_result_type exp_r;
      int bad;
      if (reset) begin
         setpoint <= fstp_pkg::SETPOINT_RST;
         err_span <= fstp_pkg::ERR_SPAN_RST;
         chg_span <= fstp_pkg::CHG_SPAN_RST;
         kp_lim <= fstp_pkg::KP_LIM_RST;
         ki_lim <= fstp_pkg::KI_LIM_RST;
         kd_lim <= fstp_pkg::KD_LIM_RST;
         err_1 = 0; err_2 = 0;
         kp_gain = 0; ki_gain = 0; kd_gain = 0;
         results_due.delete();
         errors <= 0;
         pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               fstp_pkg::REG_SETPOINT: setpoint <= csr_pwdata[15:0];
               fstp_pkg::REG_ERR_SPAN: err_span <= csr_pwdata[15:0];
               fstp_pkg::REG_CHG_SPAN: chg_span <= csr_pwdata[15:0];
               fstp_pkg::REG_KP_LIM:   kp_lim <= csr_pwdata[23:0];
               fstp_pkg::REG_KI_LIM:   ki_lim <= csr_pwdata[23:0];
               fstp_pkg::REG_KD_LIM:   kd_lim <= csr_pwdata[23:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) results_due.push_back(next_correction(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               $display("%0t unexpected result beat, expected none actual %h",
                        $time, rsp_tdata);
               errors <= errors + 1;
            end else begin
               exp_r = results_due.pop_front();
               bad = field_mismatch("correction", exp_r.correction,
                                    $signed(rsp_tdata[15:0]))
                   + field_mismatch("prop_gain", exp_r.prop_gain, rsp_tdata[47:16])
                   + field_mismatch("integ_gain", exp_r.integ_gain, rsp_tdata[79:48])
                   + field_mismatch("deriv_gain", exp_r.deriv_gain, rsp_tdata[111:80]);
               if (bad != 0) errors <= errors + 1;
            end
         end
         pending <= results_due.size();
      end
   end
endmodule

// ----- tb/sv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] REG_UNUSED = 3'd6;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [15:0]  req_tdata = 0;   // measurement
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   // correction, prop_gain, integ_gain, deriv_gain
   logic [111:0] rsp_tdata;
   logic         csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [fstp_pkg::CSR_ADDR_W-1:0] csr_paddr = 0;
   logic [31:0]  csr_pwdata = 0, csr_prdata;
   logic         csr_pready;
   int           errors, pending;
   int           burst_left = 0;
   logic [15:0]  cur_setpoint = fstp_pkg::SETPOINT_RST, cur_span = fstp_pkg::ERR_SPAN_RST;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   fuzzy_self_tuning_pid_unit i_dut (.*);

   fstp_checker i_checker (.*);

   // receiver: alternates between always ready, random stalls and long stalls
   int stall_mode = 0, mode_left = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 2000);
      end else mode_left--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 60) == 0);
      endcase
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx == fstp_pkg::REG_SETPOINT) cur_setpoint = val[15:0];
      if (idx == fstp_pkg::REG_ERR_SPAN) cur_span = val[15:0];
   endtask

   // drop the request so a held beat is not taken twice, then wait for all results
   task automatic wait_drained();
      req_tvalid <= 0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic send_sample(input logic [15:0] m);
      req_tvalid <= 1;
      req_tdata <= m;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) burst_left--;
      else begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   task automatic set_all(input logic [15:0] sp, input logic [15:0] es, input logic [15:0] cs,
                          input logic [23:0] kp, input logic [23:0] ki, input logic [23:0] kd);
      wait_drained();
      write_reg(fstp_pkg::REG_SETPOINT, 32'(sp));
      write_reg(fstp_pkg::REG_ERR_SPAN, 32'(es));
      write_reg(fstp_pkg::REG_CHG_SPAN, 32'(cs));
      write_reg(fstp_pkg::REG_KP_LIM, 32'(kp));
      write_reg(fstp_pkg::REG_KI_LIM, 32'(ki));
      write_reg(fstp_pkg::REG_KD_LIM, 32'(kd));
   endtask

   function automatic logic [15:0] near_setpoint();
      int v;
      v = int'(cur_setpoint) + $urandom_range(0, 4 * int'(cur_span) + 2)
        - 2 * int'(cur_span) - 1;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   function automatic logic [23:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom_range(0, 65536));
         default: return 24'($urandom_range(0, 24'hFFFFFF));
      endcase
   endfunction

   function automatic logic [15:0] pick_span();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 50));
         default: return 16'($urandom_range(1, 16'hFFFF));
      endcase
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      // defaults: zero error, both ends of the input, steps around the setpoint
      send_sample(16'd3000);
      send_sample(16'd0);
      send_sample(16'hFFFF);
      send_sample(16'd3000);
      send_sample(16'd1000);
      send_sample(16'd5000);
      send_sample(16'd3500);
      send_sample(16'd2999);
      wait_drained();
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      send_sample(16'd2500);
      send_sample(16'd3000);
      // zero setpoint, zero spans and largest limits: levels clamp
      set_all(16'd0, 16'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_sample(16'hFFFF);
      send_sample(16'd0);
      send_sample(16'hFFFF);
      send_sample(16'd1);
      send_sample(16'd0);
      // widest spans, top setpoint, zero limits
      set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd0, 24'd0, 24'd0);
      send_sample(16'd0);
      send_sample(16'hFFFF);
      send_sample(16'h8000);
      // zero setpoint, unit spans and largest limits
      set_all(16'd0, 16'd1, 16'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_sample(16'd0);
      send_sample(16'd100);
      send_sample(16'd0);
      send_sample(16'd50);
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0)
            set_all(fstp_pkg::SETPOINT_RST, fstp_pkg::ERR_SPAN_RST, fstp_pkg::CHG_SPAN_RST,
                    fstp_pkg::KP_LIM_RST, fstp_pkg::KI_LIM_RST, fstp_pkg::KD_LIM_RST);
         else
            set_all(16'($urandom_range(0, 16'hFFFF)), pick_span(), pick_span(), pick_limit(),
                    pick_limit(), pick_limit());
         for (int n = 0; n < 171; n++) begin
            if (n == 90) wait_drained();
            if ($urandom_range(0, 9) < 7) send_sample(near_setpoint());
            else send_sample(16'($urandom_range(0, 16'hFFFF)));
         end
      end
      wait_drained();
      repeat (400) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
